### rtl/box_frustum_classify_top_assert.svh
// Assertion macros for the box frustum classifier.
`ifndef BOX_FRUSTUM_CLASSIFY_TOP_ASSERT_SVH
`define BOX_FRUSTUM_CLASSIFY_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check while out of reset.
`define BFC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("box_frustum_classify assertion failed");

// Check at every edge, reset included.
`define BFC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("box_frustum_classify assertion failed");

`else

`define BFC_ASSERT(label, prop)
`define BFC_ASSERT_ALWAYS(label, prop)

`endif

`endif

### rtl/bfc_pkg.sv
package bfc_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int PLANE_COUNT = 6;

  localparam int COORD_W  = 24;
  localparam int SUM_W    = COORD_W + 1;
  localparam int NRM_W    = 14;
  localparam int ABS_W    = NRM_W + 1;
  localparam int OFS_W    = 22;
  localparam int OFS_LSB  = 3 * NRM_W;
  localparam int PLANE_W  = 64;
  localparam int MARGIN_W = 8;
  localparam int PROD_W   = ABS_W + SUM_W;
  localparam int ACC_W    = 44;
  localparam int FRAC_SH  = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [PLANE_W-1:0]   PLANE_RESET  = 64'd1125899906842624;
  localparam logic [MARGIN_W-1:0]  MARGIN_RESET = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 3'd6;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef enum logic [1:0] {
    REL_OUTSIDE   = 2'd0,
    REL_INTERSECT = 2'd1,
    REL_INSIDE    = 2'd2
  } relation_e;

  typedef struct packed {
    logic adv_prod;
    logic adv_sum;
  } lane_ctrl_t;

endpackage

### rtl/bfc_plane.sv
module bfc_plane (
  input  logic                               clk_i,
  input  bfc_pkg::lane_ctrl_t                ctrl_i,
  input  bfc_pkg::sum_t                      sum_i [3],
  input  bfc_pkg::sum_t                      diff_i [3],
  input  logic [bfc_pkg::PLANE_W-1:0]        plane_i,
  input  logic [bfc_pkg::MARGIN_W-1:0]       margin_i,
  output logic                               outside_o,
  output logic                               partial_o
);
  import bfc_pkg::*;

  logic signed [NRM_W-1:0]  nrm     [3];
  logic signed [ABS_W-1:0]  nrm_abs [3];
  logic signed [PROD_W-1:0] ps_d    [3];
  logic signed [PROD_W-1:0] pr_d    [3];
  logic signed [PROD_W-1:0] ps_q    [3];
  logic signed [PROD_W-1:0] pr_q    [3];
  logic signed [OFS_W-1:0]  ofs;
  logic signed [ACC_W-1:0]  dist_d, rad_d, dist_q, rad_q, tol;
  logic signed [ACC_W-1:0]  far_sum, near_sum;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nrm[a]     = $signed(plane_i[a*NRM_W +: NRM_W]);
      nrm_abs[a] = nrm[a][NRM_W-1] ? -ABS_W'(nrm[a]) : ABS_W'(nrm[a]);
      ps_d[a]    = PROD_W'(nrm[a]) * PROD_W'(sum_i[a]);
      pr_d[a]    = PROD_W'(nrm_abs[a]) * PROD_W'(diff_i[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv_prod) begin
      ps_q <= ps_d;
      pr_q <= pr_d;
    end
  end

  assign ofs    = $signed(plane_i[OFS_LSB +: OFS_W]);
  assign dist_d = ACC_W'(ps_q[0]) + ACC_W'(ps_q[1]) + ACC_W'(ps_q[2])
                + (ACC_W'(ofs) <<< FRAC_SH);
  assign rad_d  = ACC_W'(pr_q[0]) + ACC_W'(pr_q[1]) + ACC_W'(pr_q[2]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv_sum) begin
      dist_q <= dist_d;
      rad_q  <= rad_d;
    end
  end

  assign tol      = $signed({{(ACC_W-MARGIN_W-FRAC_SH){1'b0}}, margin_i, {FRAC_SH{1'b0}}});
  assign far_sum  = dist_q + rad_q + tol;
  assign near_sum = dist_q - rad_q - tol;

  assign outside_o = far_sum[ACC_W-1];
  assign partial_o = near_sum[ACC_W-1];

endmodule

### rtl/box_frustum_classify_top.sv
// Box versus frustum classifier, one box per request.
// Each box passes through registered stages in order: sum, products, plane sums, result.
// Throughput: one box per cycle; each stage stalls only when the one after it is full.
// Config writes are always ready.
// Reset: asynchronous, active low; empties the pipeline, loads accept-all planes and margin 3.
`include "box_frustum_classify_top_assert.svh"

module box_frustum_classify_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bfc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bfc_pkg::PLANE_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [bfc_pkg::COORD_W-1:0]  min_x_i,
  input  logic signed [bfc_pkg::COORD_W-1:0]  min_y_i,
  input  logic signed [bfc_pkg::COORD_W-1:0]  min_z_i,
  input  logic signed [bfc_pkg::COORD_W-1:0]  max_x_i,
  input  logic signed [bfc_pkg::COORD_W-1:0]  max_y_i,
  input  logic signed [bfc_pkg::COORD_W-1:0]  max_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          relation_o
);
  import bfc_pkg::*;

  logic [PLANE_W-1:0]  plane_q [NUM_PLANES];
  logic [MARGIN_W-1:0] margin_q;

  logic v1_q, v2_q, v3_q, out_valid_q;
  logic v1_d, v2_d, v3_d, out_valid_d;
  logic adv1, adv2, adv3, adv4;
  logic free1, free2, free3;

  logic signed [COORD_W-1:0] lo [3];
  logic signed [COORD_W-1:0] hi [3];
  sum_t s_d [3], d_d [3], s_q [3], d_q [3];

  lane_ctrl_t           lane_ctrl;
  logic [PLANE_COUNT-1:0] lane_out, lane_partial;
  logic                 any_out, any_partial;
  relation_e            relation_d, relation_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_q[p] <= PLANE_RESET;
      end
      margin_q <= MARGIN_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i < CFG_IDX_W'(NUM_PLANES)) begin
        plane_q[cfg_index_i] <= cfg_data_i;
      end else if (cfg_index_i == CFG_MARGIN) begin
        margin_q <= cfg_data_i[MARGIN_W-1:0];
      end
    end
  end

  assign adv4  = v3_q && (!out_valid_q || out_ready_i);
  assign free3 = !v3_q || adv4;
  assign adv3  = v2_q && free3;
  assign free2 = !v2_q || adv3;
  assign adv2  = v1_q && free2;
  assign free1 = !v1_q || adv2;
  assign adv1  = in_valid_i && free1;

  assign in_ready_o = free1;

  always_comb begin
    v1_d        = adv1 || (v1_q && !adv2);
    v2_d        = adv2 || (v2_q && !adv3);
    v3_d        = adv3 || (v3_q && !adv4);
    out_valid_d = adv4 || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      v3_q        <= v3_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign lo[0] = min_x_i;
  assign lo[1] = min_y_i;
  assign lo[2] = min_z_i;
  assign hi[0] = max_x_i;
  assign hi[1] = max_y_i;
  assign hi[2] = max_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s_d[a] = SUM_W'(lo[a]) + SUM_W'(hi[a]);
      d_d[a] = SUM_W'(hi[a]) - SUM_W'(lo[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s_q <= s_d;
      d_q <= d_d;
    end
  end

  assign lane_ctrl.adv_prod = adv2;
  assign lane_ctrl.adv_sum  = adv3;

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    bfc_plane u_plane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .sum_i     (s_q),
      .diff_i    (d_q),
      .plane_i   (plane_q[p]),
      .margin_i  (margin_q),
      .outside_o (lane_out[p]),
      .partial_o (lane_partial[p])
    );
  end

  assign any_out     = |lane_out;
  assign any_partial = |lane_partial;

  always_comb begin
    if (any_out) begin
      relation_d = REL_OUTSIDE;
    end else if (any_partial) begin
      relation_d = REL_INTERSECT;
    end else begin
      relation_d = REL_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      relation_q <= relation_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign relation_o  = relation_q;

  `BFC_ASSERT(a_accept_fills_s1, (in_valid_i && in_ready_o) |=> v1_q)
  `BFC_ASSERT(a_stall_holds_s3, (v3_q && out_valid_o && !out_ready_i) |=> v3_q)
  `BFC_ASSERT(a_outside_wins, (adv4 && any_out) |=> (relation_q == REL_OUTSIDE))
  `BFC_ASSERT_ALWAYS(a_reset_empties, !rst_ni |-> (!out_valid_o && !v1_q))

endmodule
